### design/slq_pkg.sv
// ----------------------------------------------------------------------------
// slq_pkg
// shared constants, codes and control types of the sorted list queue
// ----------------------------------------------------------------------------
package slq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_POP    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the request
    logic exec;  // apply the captured request to the store
  } cmd_t;

endpackage

### design/slq_ctrl.sv
// ----------------------------------------------------------------------------
// slq_ctrl
// request sequencing: accept, execute, deliver the result
// ----------------------------------------------------------------------------
module slq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output slq_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          in_ready_q <= 1'b1;
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q     <= S_DONE;
          out_valid_q <= 1'b1;
        end
        S_DONE: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b0;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.load  = in_valid_i && in_ready_q && (state_q == S_IDLE);
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

### design/slq_datapath.sv
// ----------------------------------------------------------------------------
// slq_datapath
// row of compare-and-shift cells holding the sorted entries, plus result regs
// ----------------------------------------------------------------------------
module slq_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  slq_pkg::cmd_t                        cmd_i,
  input  logic [slq_pkg::MODE_W-1:0]           mode_i,
  input  logic signed [slq_pkg::DATA_W-1:0]    data_value_i,
  output logic [slq_pkg::STATUS_W-1:0]         status_o,
  output logic signed [slq_pkg::DATA_W-1:0]    removed_value_o,
  output logic [slq_pkg::COUNT_W-1:0]          entry_count_o,
  output logic signed [slq_pkg::DATA_W-1:0]    smallest_value_o
);

  localparam int unsigned Cap = slq_pkg::CAPACITY;

  slq_pkg::mode_e                       mode_q;
  logic signed [slq_pkg::DATA_W-1:0]    value_q;
  logic signed [slq_pkg::DATA_W-1:0]    entries_q [Cap];
  logic signed [slq_pkg::DATA_W-1:0]    entries_d [Cap];
  logic [slq_pkg::CNT_W-1:0]            count_q, count_d;
  slq_pkg::status_e                     status_q, status_d;
  logic signed [slq_pkg::DATA_W-1:0]    removed_q, removed_d;
  logic signed [slq_pkg::DATA_W-1:0]    smallest_q, smallest_d;

  logic [Cap-1:0] occ;   // cell holds a live entry
  logic [Cap-1:0] lt;    // live entry smaller than the operand
  logic [Cap-1:0] hit;   // live entry equal to the operand
  logic           found;
  logic           full;
  logic [31:0]    count_ext;

  always_comb begin
    for (int i = 0; i < Cap; i++) begin
      occ[i] = (slq_pkg::CNT_W'(i) < count_q);
      lt[i]  = occ[i] && (entries_q[i] < value_q);
      hit[i] = occ[i] && (entries_q[i] == value_q);
    end
  end

  assign found = |hit;
  assign full  = (count_q == slq_pkg::CNT_W'(Cap));

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    status_d  = slq_pkg::ST_OK;
    removed_d = '0;
    unique case (mode_q)
      slq_pkg::MODE_INSERT: begin
        if (full) begin
          status_d = slq_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < Cap; i++) begin
            if (!lt[i]) begin
              if (i == 0) begin
                entries_d[i] = value_q;
              end else if (lt[i-1]) begin
                entries_d[i] = value_q;
              end else begin
                entries_d[i] = entries_q[i-1];
              end
            end
          end
          count_d = count_q + 1'b1;
        end
      end
      slq_pkg::MODE_DELETE: begin
        if (!found) begin
          status_d = slq_pkg::ST_NOT_FOUND;
        end else begin
          // equal entries sit in one run starting at the first non-smaller cell
          for (int i = 0; i < Cap - 1; i++) begin
            if (!lt[i]) begin
              entries_d[i] = entries_q[i+1];
            end
          end
          removed_d = value_q;
          count_d   = count_q - 1'b1;
        end
      end
      slq_pkg::MODE_POP: begin
        if (count_q == '0) begin
          status_d = slq_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < Cap - 1; i++) begin
            entries_d[i] = entries_q[i+1];
          end
          removed_d = entries_q[0];
          count_d   = count_q - 1'b1;
        end
      end
      slq_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    smallest_d = (count_d != '0) ? entries_d[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= slq_pkg::mode_e'(mode_i);
      value_q <= data_value_i;
    end
    if (cmd_i.exec) begin
      entries_q  <= entries_d;
      status_q   <= status_d;
      removed_q  <= removed_d;
      smallest_q <= smallest_d;
    end
  end

  assign count_ext        = 32'(count_q);
  assign status_o         = status_q;
  assign removed_value_o  = removed_q;
  assign entry_count_o    = count_ext[slq_pkg::COUNT_W-1:0];
  assign smallest_value_o = smallest_q;

endmodule

### design/sorted_list_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_list_queue_top
// bounded ascending priority queue of signed 32-bit values
// ----------------------------------------------------------------------------
// each request carries a mode (insert, delete matching value, pop smallest,
// clear) and a value, and yields exactly one result with a status, the value
// taken out (zero if none), the entry count after the request and the
// smallest stored value (zero when empty). entries live in a row of
// compare-and-shift cells, so any request is applied to the whole store in
// its execute step; the result is offered once the controller has passed
// from execute to deliver, waits there for out_ready_i, and the next request
// is taken in the cycle after the result leaves, so a request passes through
// three steps (accept, execute, deliver). the time a request takes is set by
// the controller sequence, not by the store size. a new value is placed
// ahead of any equal stored values; no clearing pass is needed after reset
// since only entries below the count are read
// ----------------------------------------------------------------------------
module sorted_list_queue_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [slq_pkg::MODE_W-1:0]           mode_i,
  input  logic signed [slq_pkg::DATA_W-1:0]    data_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [slq_pkg::STATUS_W-1:0]         status_o,
  output logic signed [slq_pkg::DATA_W-1:0]    removed_value_o,
  output logic [slq_pkg::COUNT_W-1:0]          entry_count_o,
  output logic signed [slq_pkg::DATA_W-1:0]    smallest_value_o
);

  slq_pkg::cmd_t cmd;

  // sequencer: holds handshakes and tells the datapath when to capture/apply
  slq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // sorted store and registered result fields
  slq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .mode_i           (mode_i),
    .data_value_i     (data_value_i),
    .status_o         (status_o),
    .removed_value_o  (removed_value_o),
    .entry_count_o    (entry_count_o),
    .smallest_value_o (smallest_value_o)
  );

endmodule
